// ===== src/lltc_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD line timing package
// Shared types and constants: request/response beats, register map, modes.
// ----------------------------------------------------------------------------
`default_nettype none

package lltc_pkg;

   // Timing constants
   localparam logic [8:0] DOTS_PER_LINE = 9'd456;
   localparam logic [7:0] VISIBLE_LINES = 8'd144;
   localparam logic [7:0] TOTAL_LINES   = 8'd154;
   localparam logic [8:0] OAM_SCAN_DOTS = 9'd80;
   localparam logic [7:0] VISIBLE_WIDTH = 8'd160;
   localparam logic [7:0] WX_MAX        = VISIBLE_WIDTH + 8'd6;
   localparam logic [8:0] DOT_MAX       = 9'd511;

   // Operations
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Modes (status bits 1:0)
   localparam logic [1:0] MODE_HBLANK  = 2'd0;
   localparam logic [1:0] MODE_VBLANK  = 2'd1;
   localparam logic [1:0] MODE_OAM     = 2'd2;
   localparam logic [1:0] MODE_DRAWING = 2'd3;

   // Register map
   localparam logic [15:0] ADDR_LCDC = 16'hFF40;
   localparam logic [15:0] ADDR_STAT = 16'hFF41;
   localparam logic [15:0] ADDR_SCY  = 16'hFF42;
   localparam logic [15:0] ADDR_SCX  = 16'hFF43;
   localparam logic [15:0] ADDR_LY   = 16'hFF44;
   localparam logic [15:0] ADDR_LYC  = 16'hFF45;
   localparam logic [15:0] ADDR_BGP  = 16'hFF47;
   localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
   localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
   localparam logic [15:0] ADDR_WY   = 16'hFF4A;
   localparam logic [15:0] ADDR_WX   = 16'hFF4B;

   localparam logic [7:0] STAT_RESET     = 8'h02;
   localparam logic [7:0] STAT_KEEP_MASK = 8'h87;
   localparam logic [7:0] STAT_WR_MASK   = 8'h78;
   localparam logic [7:0] OBP_WR_MASK    = 8'hFC;
   localparam logic [7:0] READ_UNMAPPED  = 8'hFF;

   // Status bit positions
   localparam int STAT_COINC_BIT = 2;
   localparam int STAT_HBL_IE    = 3;
   localparam int STAT_VBL_IE    = 4;
   localparam int STAT_LYC_IE    = 6;
   localparam int LCDC_WIN_EN    = 5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        drawing_done;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] lcd_mode;
      logic [7:0] current_line;
      logic [7:0] window_line_count;
      logic       start_drawing;
      logic       vblank_irq;
      logic       lcd_irq;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/lcd_line_timing_controller.sv =====
// ----------------------------------------------------------------------------
// LCD line timing controller
// Display timing, STAT/LY registers and interrupt requests of the video unit.
// ----------------------------------------------------------------------------
// One request beat (dot tick, register read or register write) is taken per
// clock and answered by exactly one response beat in the following cycle. The
// register state updates at the request handshake; the response register
// holds the read data, the mode, LY and the window line as they stand after
// that beat, plus the start-drawing, vblank and STAT interrupt pulses. The
// request side stays ready while the response register is empty or being
// drained, so with rsp_ready held high the block sustains one beat per clock.
`default_nettype none

module lcd_line_timing_controller
   import lltc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    step_en;
   rsp_type step_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step_en   = req_valid && req_ready;

   lltc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_data),
      .rsp     (step_rsp)
   );

   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every accepted beat shows up as a response on the next cycle
   a_step_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid)
      else $error("accepted beat produced no response");

   a_start_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.start_drawing) |-> (rsp_data.lcd_mode == MODE_DRAWING))
      else $error("start_drawing outside drawing mode");

   a_vbl_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.vblank_irq) |->
         (rsp_data.lcd_mode == MODE_VBLANK && rsp_data.current_line >= VISIBLE_LINES))
      else $error("vblank request without entering vblank");

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.start_drawing && rsp_data.vblank_irq))
      else $error("start_drawing and vblank in one beat");

endmodule

`default_nettype wire

// ===== src/lltc_core.sv =====
// ----------------------------------------------------------------------------
// LCD line timing core
// Register file, dot counter and mode sequencer; one beat per cycle while step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lltc_core
   import lltc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp
);

   logic [7:0] lcdc_ff, lcdc_in;
   logic [7:0] stat_ff, stat_in;
   logic [7:0] scy_ff, scy_in;
   logic [7:0] scx_ff, scx_in;
   logic [7:0] ly_ff, ly_in;
   logic [7:0] lyc_ff, lyc_in;
   logic [7:0] bgp_ff, bgp_in;
   logic [7:0] obp0_ff, obp0_in;
   logic [7:0] obp1_ff, obp1_in;
   logic [7:0] wy_ff, wy_in;
   logic [7:0] wx_ff, wx_in;
   logic [8:0] dot_ff, dot_in;
   logic [7:0] win_line_ff, win_line_in;

   logic [8:0] dot_inc;
   logic [7:0] ly_p1;
   logic       win_on_line;
   logic       lyc_hit;
   logic       line_end;
   logic [7:0] rd_data;
   logic       start_pulse, vbl_pulse, lcd_pulse;

   assign dot_inc     = (dot_ff < DOT_MAX) ? dot_ff + 9'd1 : dot_ff;
   assign ly_p1       = ly_ff + 8'd1;
   assign lyc_hit     = (ly_p1 == lyc_ff);
   assign line_end    = (dot_inc >= DOTS_PER_LINE);
   assign win_on_line = lcdc_ff[LCDC_WIN_EN] && (wx_ff <= WX_MAX)
                        && (wy_ff < VISIBLE_LINES) && (ly_ff >= wy_ff);

   always_comb begin
      unique case (req.address)
         ADDR_LCDC: rd_data = lcdc_ff;
         ADDR_STAT: rd_data = stat_ff;
         ADDR_SCY:  rd_data = scy_ff;
         ADDR_SCX:  rd_data = scx_ff;
         ADDR_LY:   rd_data = ly_ff;
         ADDR_LYC:  rd_data = lyc_ff;
         ADDR_BGP:  rd_data = bgp_ff;
         ADDR_OBP0: rd_data = obp0_ff;
         ADDR_OBP1: rd_data = obp1_ff;
         ADDR_WY:   rd_data = wy_ff;
         ADDR_WX:   rd_data = wx_ff;
         default:   rd_data = READ_UNMAPPED;
      endcase
   end

   always_comb begin
      lcdc_in     = lcdc_ff;
      stat_in     = stat_ff;
      scy_in      = scy_ff;
      scx_in      = scx_ff;
      ly_in       = ly_ff;
      lyc_in      = lyc_ff;
      bgp_in      = bgp_ff;
      obp0_in     = obp0_ff;
      obp1_in     = obp1_ff;
      wy_in       = wy_ff;
      wx_in       = wx_ff;
      dot_in      = dot_ff;
      win_line_in = win_line_ff;
      start_pulse = 1'b0;
      vbl_pulse   = 1'b0;
      lcd_pulse   = 1'b0;

      unique case (req.operation)
         OP_TICK: begin
            dot_in = dot_inc;
            unique case (stat_ff[1:0])
               MODE_HBLANK, MODE_VBLANK: begin
                  if (line_end) begin
                     // advance LY and refresh the coincidence flag
                     if (win_on_line) begin
                        win_line_in = win_line_ff + 8'd1;
                     end
                     ly_in = ly_p1;
                     stat_in[STAT_COINC_BIT] = lyc_hit;
                     lcd_pulse = lyc_hit && stat_ff[STAT_LYC_IE];
                     dot_in = '0;
                     if (stat_ff[1:0] == MODE_HBLANK) begin
                        if (ly_p1 >= VISIBLE_LINES) begin
                           stat_in[1:0] = MODE_VBLANK;
                           vbl_pulse = 1'b1;
                           if (stat_ff[STAT_VBL_IE]) begin
                              lcd_pulse = 1'b1;
                           end
                        end else begin
                           stat_in[1:0] = MODE_OAM;
                        end
                     end else if (ly_p1 >= TOTAL_LINES) begin
                        stat_in[1:0] = MODE_OAM;
                        ly_in        = '0;
                        win_line_in  = '0;
                     end
                  end
               end
               MODE_OAM: begin
                  if (dot_inc >= OAM_SCAN_DOTS) begin
                     stat_in[1:0] = MODE_DRAWING;
                     start_pulse  = 1'b1;
                  end
               end
               default: begin
                  if (req.drawing_done) begin
                     stat_in[1:0] = MODE_HBLANK;
                     lcd_pulse    = stat_ff[STAT_HBL_IE];
                  end
               end
            endcase
         end
         OP_WRITE: begin
            unique case (req.address)
               ADDR_LCDC: lcdc_in = req.write_data;
               ADDR_STAT: stat_in = (stat_ff & STAT_KEEP_MASK)
                                    | (req.write_data & STAT_WR_MASK);
               ADDR_SCY:  scy_in  = req.write_data;
               ADDR_SCX:  scx_in  = req.write_data;
               ADDR_LY:   ly_in   = '0;
               ADDR_LYC:  lyc_in  = req.write_data;
               ADDR_BGP:  bgp_in  = req.write_data;
               ADDR_OBP0: obp0_in = req.write_data & OBP_WR_MASK;
               ADDR_OBP1: obp1_in = req.write_data & OBP_WR_MASK;
               ADDR_WY:   wy_in   = req.write_data;
               ADDR_WX:   wx_in   = req.write_data;
               default:   ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.read_data         = (req.operation == OP_READ) ? rd_data : 8'h00;
      rsp.lcd_mode          = stat_in[1:0];
      rsp.current_line      = ly_in;
      rsp.window_line_count = win_line_in;
      rsp.start_drawing     = start_pulse;
      rsp.vblank_irq        = vbl_pulse;
      rsp.lcd_irq           = lcd_pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff     <= '0;
         stat_ff     <= STAT_RESET;
         scy_ff      <= '0;
         scx_ff      <= '0;
         ly_ff       <= '0;
         lyc_ff      <= '0;
         bgp_ff      <= '0;
         obp0_ff     <= '0;
         obp1_ff     <= '0;
         wy_ff       <= '0;
         wx_ff       <= '0;
         dot_ff      <= '0;
         win_line_ff <= '0;
      end else if (step_en) begin
         lcdc_ff     <= lcdc_in;
         stat_ff     <= stat_in;
         scy_ff      <= scy_in;
         scx_ff      <= scx_in;
         ly_ff       <= ly_in;
         lyc_ff      <= lyc_in;
         bgp_ff      <= bgp_in;
         obp0_ff     <= obp0_in;
         obp1_ff     <= obp1_in;
         wy_ff       <= wy_in;
         wx_ff       <= wx_in;
         dot_ff      <= dot_in;
         win_line_ff <= win_line_in;
      end
   end

endmodule

`default_nettype wire
